[sv/asmq_pkg.sv]
// ----------------------------------------------------------------------------
// asmq_pkg
// Shared types and constants of the audio sample mix queue: store geometry,
// operation and mode codes, register indexes and the shared-unit interface.
// ----------------------------------------------------------------------------
package asmq_pkg;

    // store geometry
    localparam int DEPTH      = 16384;
    localparam int PRIME      = 4096;
    localparam int ENTRY_BITS = 24;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FILL_W     = $clog2(DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int OFFSET_W = 14;
    localparam int LEVEL_W  = 15;
    localparam int MODE_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // compare width for level against thresholds
    localparam int CMP_W = ((FILL_W > LEVEL_W) ? FILL_W : LEVEL_W) + 1;

    // shared unit widths
    localparam int ALU_W       = 32;
    localparam int MUL_W       = GAIN_W + 1;
    localparam int SCALE_SHIFT = 14;
    localparam int GAIN_ONE    = 1 << SCALE_SHIFT;

    // output saturation bounds
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // register reset values
    localparam logic [MODE_W-1:0]  MODE_RESET = MODE_W'(2);
    localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(GAIN_ONE);
    localparam logic [LEVEL_W-1:0] LOW_RESET  = LEVEL_W'(4096);
    localparam logic [LEVEL_W-1:0] HIGH_RESET = LEVEL_W'(8192);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_MIX   = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_OFF  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_RAW  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_GAIN = MODE_W'(2);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = CFG_IDX_W'(3);

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SCALE,
        ALU_ADD_SAT,
        ALU_ADD_WRAP
    } alu_op_t;

    typedef struct packed {
        alu_op_t                 op;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } alu_req_t;

    // store access request
    typedef struct packed {
        logic                         we;
        logic                         re;
        logic [ADDR_W-1:0]            addr;
        logic signed [ENTRY_BITS-1:0] wdata;
    } ram_req_t;

endpackage

[sv/asmq_ram.sv]
// ----------------------------------------------------------------------------
// asmq_ram
// Single-port sample store: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module asmq_ram import asmq_pkg::*; (
    input  logic                         aclk,
    input  ram_req_t                     req,
    output logic signed [ENTRY_BITS-1:0] rdata
);

    logic signed [ENTRY_BITS-1:0] mem [DEPTH];
    logic signed [ENTRY_BITS-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/asmq_alu.sv]
// ----------------------------------------------------------------------------
// asmq_alu
// Shared arithmetic unit: gain multiply, scale toward zero, saturating add
// into an entry, and circular address add.
// ----------------------------------------------------------------------------
module asmq_alu import asmq_pkg::*; (
    input  alu_req_t                req,
    output logic signed [ALU_W-1:0] result
);

    localparam longint ENTRY_MAX_L = (64'sd1 <<< (ENTRY_BITS - 1)) - 64'sd1;
    localparam logic signed [ALU_W:0] ENTRY_MAX = (ALU_W + 1)'(ENTRY_MAX_L);
    localparam logic signed [ALU_W:0] ENTRY_MIN = (ALU_W + 1)'(-ENTRY_MAX_L - 64'sd1);
    localparam logic signed [ALU_W-1:0] SCALE_BIAS = ALU_W'(GAIN_ONE - 1);
    localparam logic [ALU_W-1:0] DEPTH_U = ALU_W'(DEPTH);

    logic signed [2*MUL_W-1:0] prod;
    logic signed [ALU_W:0]     sum;
    logic signed [ALU_W-1:0]   biased;
    logic [ALU_W-1:0]          usum;

    always_comb begin
        prod   = $signed(req.a[MUL_W-1:0]) * $signed(req.b[MUL_W-1:0]);
        sum    = {req.a[ALU_W-1], req.a} + {req.b[ALU_W-1], req.b};
        biased = req.a + (req.a[ALU_W-1] ? SCALE_BIAS : '0);
        usum   = req.a + req.b;
        result = '0;
        unique case (req.op)
            // product of sample and gain
            ALU_MUL: begin
                result = prod[ALU_W-1:0];
            end
            // divide by unity gain, truncating toward zero
            ALU_SCALE: begin
                result = biased >>> SCALE_SHIFT;
            end
            // add and clamp to the entry range
            ALU_ADD_SAT: begin
                if (sum > ENTRY_MAX) begin
                    result = ENTRY_MAX[ALU_W-1:0];
                end else if (sum < ENTRY_MIN) begin
                    result = ENTRY_MIN[ALU_W-1:0];
                end else begin
                    result = sum[ALU_W-1:0];
                end
            end
            // position from head to store slot
            ALU_ADD_WRAP: begin
                if (usum >= DEPTH_U) begin
                    result = usum - DEPTH_U;
                end else begin
                    result = usum;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

[sv/audio_sample_mix_queue.sv]
// ----------------------------------------------------------------------------
// audio_sample_mix_queue
// Mono fixed-point sample queue with push, mix at offset and drain.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 16384-entry store to zero, one entry a
// cycle, and holds s_ready low for the whole sweep; configuration writes
// are taken throughout. Each beat then runs through a small sequencer that
// drives one shared arithmetic unit and one single-port store: a push runs
// multiply, scale, address wrap and write back, a mix adds a read before
// the write back, a drain that finds data reads and writes back, and an
// ignored, refused or empty operation goes straight to the result. The
// shared unit serves multiply, scale, address wrap and saturating add in
// turn. The result beat sits in an output register; a new beat is accepted
// while it waits, and the sequencer stalls only at loading the next result.
// ----------------------------------------------------------------------------
module audio_sample_mix_queue import asmq_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wr_data,
    // input beats
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [OP_W-1:0]             s_op,
    input  logic signed [SAMPLE_W-1:0]  s_sample_in,
    input  logic [OFFSET_W-1:0]         s_offset,
    // result beats
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_sample_out,
    output logic                        m_had_data,
    output logic                        m_dropped,
    output logic [LEVEL_W-1:0]          m_level,
    output logic [LEVEL_W-1:0]          m_shortage,
    output logic [LEVEL_W-1:0]          m_excess
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_ADDR,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } state_t;

    localparam logic signed [ENTRY_BITS-1:0] ENTRY_SMAX = ENTRY_BITS'(SAMPLE_MAX);
    localparam logic signed [ENTRY_BITS-1:0] ENTRY_SMIN = ENTRY_BITS'(SAMPLE_MIN);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);

    state_t                       state_reg;
    logic [ADDR_W-1:0]            clr_cnt_reg;
    logic [MODE_W-1:0]            mode_reg;
    logic [GAIN_W-1:0]            gain_reg;
    logic [LEVEL_W-1:0]           low_reg;
    logic [LEVEL_W-1:0]           high_reg;
    logic [ADDR_W-1:0]            head_reg;
    logic [FILL_W-1:0]            fill_reg;
    op_t                          op_reg;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic [OFFSET_W-1:0]          offset_reg;
    logic signed [ALU_W-1:0]      acc_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic signed [SAMPLE_W-1:0]   res_sample_reg;
    logic                         res_had_reg;
    logic                         res_drop_reg;
    logic                         m_valid_reg;
    logic signed [SAMPLE_W-1:0]   m_sample_reg;
    logic                         m_had_reg;
    logic                         m_drop_reg;
    logic [LEVEL_W-1:0]           m_level_reg;
    logic [LEVEL_W-1:0]           m_short_reg;
    logic [LEVEL_W-1:0]           m_excess_reg;

    alu_req_t                     alu_req;
    logic signed [ALU_W-1:0]      alu_result;
    ram_req_t                     ram_req;
    logic signed [ENTRY_BITS-1:0] ram_rdata;

    logic                         in_beat;
    logic                         active;
    logic                         out_free;
    op_t                          in_op;
    logic [CMP_W-1:0]             fill_cmp;
    logic [CMP_W-1:0]             low_cmp;
    logic [CMP_W-1:0]             high_cmp;
    logic [CMP_W-1:0]             short_val;
    logic [CMP_W-1:0]             excess_val;
    logic signed [SAMPLE_W-1:0]   drain_val;

    asmq_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    asmq_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign in_op    = op_t'(s_op);
    assign active   = (mode_reg == MODE_RAW) || (mode_reg == MODE_GAIN);
    assign out_free = !m_valid_reg || m_ready;

    // status of the level against the thresholds
    assign fill_cmp   = CMP_W'(fill_reg);
    assign low_cmp    = CMP_W'(low_reg);
    assign high_cmp   = CMP_W'(high_reg);
    assign short_val  = (fill_cmp < low_cmp) ? (low_cmp - fill_cmp) : '0;
    assign excess_val = (fill_cmp > high_cmp) ? (fill_cmp - high_cmp) : '0;

    // head entry clamped to the output range
    always_comb begin
        if (ram_rdata > ENTRY_SMAX) begin
            drain_val = SAMPLE_W'(SAMPLE_MAX);
        end else if (ram_rdata < ENTRY_SMIN) begin
            drain_val = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            drain_val = ram_rdata[SAMPLE_W-1:0];
        end
    end

    // shared unit operands per step
    always_comb begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(sample_reg);
        alu_req.b  = (mode_reg == MODE_GAIN) ? ALU_W'(gain_reg) : ALU_W'(GAIN_ONE);
        unique case (state_reg)
            ST_SCALE: begin
                alu_req.op = ALU_SCALE;
                alu_req.a  = acc_reg;
                alu_req.b  = '0;
            end
            ST_ADDR: begin
                alu_req.op = ALU_ADD_WRAP;
                alu_req.a  = ALU_W'(head_reg);
                alu_req.b  = (op_reg == OP_PUSH) ? ALU_W'(fill_reg) : ALU_W'(offset_reg);
            end
            ST_UPDATE: begin
                alu_req.op = ALU_ADD_SAT;
                alu_req.a  = acc_reg;
                alu_req.b  = (op_reg == OP_MIX) ? ALU_W'(ram_rdata) : '0;
            end
            default: begin
                alu_req.op = ALU_MUL;
            end
        endcase
    end

    // store port per step
    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.re    = 1'b0;
        ram_req.addr  = addr_reg;
        ram_req.wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_req.we   = 1'b1;
                ram_req.addr = clr_cnt_reg;
            end
            ST_READ: begin
                ram_req.re = 1'b1;
            end
            ST_UPDATE: begin
                ram_req.we = 1'b1;
                if (op_reg != OP_DRAIN) begin
                    ram_req.wdata = alu_result[ENTRY_BITS-1:0];
                end
            end
            default: begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            gain_reg <= GAIN_RESET;
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE: mode_reg <= cfg_wr_data[MODE_W-1:0];
                REG_GAIN: gain_reg <= cfg_wr_data[GAIN_W-1:0];
                REG_LOW:  low_reg  <= cfg_wr_data[LEVEL_W-1:0];
                REG_HIGH: high_reg <= cfg_wr_data[LEVEL_W-1:0];
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    // sequencer, queue pointers and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            fill_reg    <= FILL_W'(PRIME);
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // zero sweep of the store
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                // take a beat and pick its path
                ST_IDLE: begin
                    if (in_beat) begin
                        op_reg         <= in_op;
                        sample_reg     <= s_sample_in;
                        offset_reg     <= s_offset;
                        res_sample_reg <= '0;
                        res_had_reg    <= 1'b0;
                        priority if (in_op == OP_PUSH && active) begin
                            if (fill_reg >= FILL_FULL) begin
                                res_drop_reg <= 1'b1;
                                state_reg    <= ST_DONE;
                            end else begin
                                res_drop_reg <= 1'b0;
                                state_reg    <= ST_MUL;
                            end
                        end else if (in_op == OP_MIX && active) begin
                            if (32'(s_offset) >= DEPTH) begin
                                res_drop_reg <= 1'b1;
                                state_reg    <= ST_DONE;
                            end else begin
                                res_drop_reg <= 1'b0;
                                state_reg    <= ST_MUL;
                            end
                        end else if (in_op == OP_DRAIN && fill_reg != '0) begin
                            res_drop_reg <= 1'b0;
                            addr_reg     <= head_reg;
                            state_reg    <= ST_READ;
                        end else begin
                            res_drop_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end
                    end
                end
                // sample times gain
                ST_MUL: begin
                    acc_reg   <= alu_result;
                    state_reg <= ST_SCALE;
                end
                // back to sample units
                ST_SCALE: begin
                    acc_reg   <= alu_result;
                    state_reg <= ST_ADDR;
                end
                // slot of the target entry
                ST_ADDR: begin
                    addr_reg  <= alu_result[ADDR_W-1:0];
                    state_reg <= (op_reg == OP_PUSH) ? ST_UPDATE : ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_UPDATE;
                end
                // write back and move the pointers
                ST_UPDATE: begin
                    state_reg <= ST_DONE;
                    unique case (op_reg)
                        OP_PUSH: begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        OP_MIX: begin
                            if (FILL_W'(offset_reg) >= fill_reg) begin
                                fill_reg <= FILL_W'(offset_reg) + 1'b1;
                            end
                        end
                        OP_DRAIN: begin
                            res_sample_reg <= drain_val;
                            res_had_reg    <= 1'b1;
                            fill_reg       <= fill_reg - 1'b1;
                            head_reg       <= (head_reg == ADDR_LAST) ? '0 : head_reg + 1'b1;
                        end
                        default: begin
                            fill_reg <= fill_reg;
                        end
                    endcase
                end
                // load the result beat once the output is free
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= res_sample_reg;
                        m_had_reg    <= res_had_reg;
                        m_drop_reg   <= res_drop_reg;
                        m_level_reg  <= LEVEL_W'(fill_reg);
                        m_short_reg  <= short_val[LEVEL_W-1:0];
                        m_excess_reg <= excess_val[LEVEL_W-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_had_data   = m_had_reg;
    assign m_dropped    = m_drop_reg;
    assign m_level      = m_level_reg;
    assign m_shortage   = m_short_reg;
    assign m_excess     = m_excess_reg;

endmodule

[sv/asmq_checker.sv]
// ----------------------------------------------------------------------------
// asmq_checker
// Port-level checks of the audio sample mix queue, bound to the top level.
// ----------------------------------------------------------------------------
module asmq_checker import asmq_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_sample_out,
    input logic                       m_had_data,
    input logic                       m_dropped,
    input logic [LEVEL_W-1:0]         m_level
);

    // store sweep keeps the input closed right after reset
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during store sweep");

    // a drain that found data never reports a refused write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_had_data && m_dropped))
        else $error("had_data and dropped both set");

    // no data means a silent sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_had_data |-> m_sample_out == '0)
        else $error("nonzero sample without data");

    // level never passes capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_level) <= DEPTH)
        else $error("level beyond capacity");

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_sample_out))
        else $error("result beat changed while stalled");

endmodule

bind audio_sample_mix_queue asmq_checker u_asmq_checker (.*);
